// ===== sv/slid_pkg.sv =====
// ----------------------------------------------------------------------------
// slid_pkg: shared types for the sorted list insert/delete core
// Action codes, fixed field widths and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package slid_pkg;

   localparam int DATA_W  = 32;
   localparam int POS_W   = 3;
   localparam int COUNT_W = 4;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_READ   = 2'd3
   } slid_action_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic                     insert_en;
      logic                     delete_en;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } slid_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/slid_cell.sv =====
// ----------------------------------------------------------------------------
// slid_cell: one slot of the sorted row
// Holds one entry; keeps it, takes the left neighbor's entry, takes the new
// value, or takes the right neighbor's entry, all decided locally.
// ----------------------------------------------------------------------------
`default_nettype none

module slid_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 4
) (
   input  wire                                   clock,
   input  wire slid_pkg::slid_ctrl_type          ctrl,
   input  wire [CNT_W-1:0]                       count,
   input  wire signed [slid_pkg::DATA_W-1:0]     left_entry,
   input  wire                                   left_gt,
   input  wire signed [slid_pkg::DATA_W-1:0]     right_entry,
   output logic signed [slid_pkg::DATA_W-1:0]    entry,
   output logic                                  gt
);

   localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

   logic signed [slid_pkg::DATA_W-1:0] entry_ff;
   logic signed [slid_pkg::DATA_W-1:0] entry_in;
   logic                               occupied;
   logic [CNT_W-1:0]                   pos_ext;

   assign occupied = (IDX < count);
   assign pos_ext  = CNT_W'(ctrl.position);
   assign gt       = occupied && (entry_ff > ctrl.value);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en) begin
         if (occupied && !gt) begin
            entry_in = entry_ff;
         end else if (left_gt) begin
            entry_in = left_entry;
         end else if (IDX <= count) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.delete_en) begin
         // close the gap from the deleted slot up to the last valid entry
         if ((IDX >= pos_ext) && (IDX_NEXT < count)) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== sv/sorted_list_insert_delete_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_core: ascending list of signed words
// Insert, delete, clear and read over a row of cells that shift in place.
// ----------------------------------------------------------------------------
// Each accepted word gives its single result strobe in the next cycle.
// Throughput: one word per cycle; busy stays low, every cell updates in the
// same cycle, set by the compare in each cell and the read select over the row.
// The receiver cannot stall; results appear for one cycle on rsp_valid.
// Reset clears the entry count and the result strobe; cell contents keep
// their bits and are only read below the count.
`default_nettype none

module sorted_list_insert_delete_core #(
   parameter int CAPACITY = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire [1:0]                           req_action,
   input  wire signed [slid_pkg::DATA_W-1:0]   req_value,
   input  wire [slid_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_valid,
   output logic                                rsp_ok,
   output logic [slid_pkg::COUNT_W-1:0]        rsp_count,
   output logic signed [slid_pkg::DATA_W-1:0]  rsp_read_value
);

   localparam int CW_RAW = $clog2(CAPACITY + 1);
   localparam int CNT_W  = (CW_RAW > slid_pkg::COUNT_W) ? CW_RAW : slid_pkg::COUNT_W;
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic                               rsp_valid_ff;
   logic                               rsp_ok_ff;
   logic [slid_pkg::COUNT_W-1:0]       rsp_count_ff;
   logic signed [slid_pkg::DATA_W-1:0] rsp_read_value_ff;

   logic                               accept;
   logic [CNT_W-1:0]                   pos_ext;
   logic                               pos_hit;
   logic                               full;
   logic                               ok_now;
   logic signed [slid_pkg::DATA_W-1:0] read_now;
   logic signed [slid_pkg::DATA_W-1:0] sel_entry;
   slid_pkg::slid_ctrl_type            ctrl;
   slid_pkg::slid_action_type          action;

   logic signed [slid_pkg::DATA_W-1:0] entries [CAPACITY];
   logic                               gts     [CAPACITY];

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign action  = slid_pkg::slid_action_type'(req_action);
   assign pos_ext = CNT_W'(req_position);
   assign pos_hit = (pos_ext < count_ff);
   assign full    = (count_ff >= CAP_C);

   assign ctrl.insert_en = accept && (action == slid_pkg::ACT_INSERT) && !full;
   assign ctrl.delete_en = accept && (action == slid_pkg::ACT_DELETE) && pos_hit;
   assign ctrl.value     = req_value;
   assign ctrl.position  = req_position;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic signed [slid_pkg::DATA_W-1:0] left_e;
         logic                               left_g;
         logic signed [slid_pkg::DATA_W-1:0] right_e;
         if (g == 0) begin : g_first
            assign left_e = '0;
            assign left_g = 1'b0;
         end else begin : g_mid
            assign left_e = entries[g-1];
            assign left_g = gts[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign right_e = '0;
         end else begin : g_inner
            assign right_e = entries[g+1];
         end
         slid_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .count       (count_ff),
            .left_entry  (left_e),
            .left_gt     (left_g),
            .right_entry (right_e),
            .entry       (entries[g]),
            .gt          (gts[g])
         );
      end
   endgenerate

   // select the addressed cell
   always_comb begin
      sel_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (pos_ext == CNT_W'(i)) begin
            sel_entry = entries[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      ok_now   = 1'b0;
      read_now = '0;
      case (action)
         slid_pkg::ACT_INSERT: begin
            ok_now = !full;
            if (!full) count_in = count_ff + CNT_W'(1);
         end
         slid_pkg::ACT_DELETE: begin
            ok_now = pos_hit;
            if (pos_hit) count_in = count_ff - CNT_W'(1);
         end
         slid_pkg::ACT_CLEAR: begin
            ok_now   = 1'b1;
            count_in = '0;
         end
         slid_pkg::ACT_READ: begin
            ok_now = pos_hit;
            if (pos_hit) read_now = sel_entry;
         end
         default: begin
            ok_now = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff         <= ok_now;
         rsp_count_ff      <= count_in[slid_pkg::COUNT_W-1:0];
         rsp_read_value_ff <= read_now;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_read_value = rsp_read_value_ff;

`ifndef NO_ASSERTIONS
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(accept))
      else $error("result strobe does not follow accepted word");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("entry count above capacity");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && (req_action == slid_pkg::ACT_CLEAR) |=> rsp_ok && (count_ff == '0))
      else $error("clear did not empty the list");

   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> count_ff == $past(count_ff))
      else $error("failed word changed the count");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_value != '0) |-> rsp_ok)
      else $error("read value on a failed word");
`endif

endmodule

`default_nettype wire
